[rtl/core/cau_pkg.sv]
package cau_pkg;

    // request codes on the input port
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_MAG2 = 3'd4;
    localparam logic [2:0] OP_MAG  = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [6:0] {
        K_NOP  = 7'b0000001,
        K_ADD  = 7'b0000010,
        K_SUB  = 7'b0000100,
        K_MUL  = 7'b0001000,
        K_DIV  = 7'b0010000,
        K_MAG2 = 7'b0100000,
        K_MAG  = 7'b1000000
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  bzero;
    } t_ctrl;

endpackage

[rtl/core/cau_front.sv]
module cau_front
    import cau_pkg::*;
#(
    parameter int W = 32
) (
    input  logic [2:0]          i_req_type,
    input  logic signed [W-1:0] i_a_re,
    input  logic signed [W-1:0] i_a_im,
    input  logic signed [W-1:0] i_b_re,
    input  logic signed [W-1:0] i_b_im,
    output t_ctrl               o_ctrl,
    output logic signed [W-1:0] o_b_re,
    output logic signed [W-1:0] o_b_im
);

    always_comb begin
        o_ctrl.bzero = (i_b_re == '0) && (i_b_im == '0);
        unique case (i_req_type)
            OP_ADD:  o_ctrl.kind = K_ADD;
            OP_SUB:  o_ctrl.kind = K_SUB;
            OP_MUL:  o_ctrl.kind = K_MUL;
            OP_DIV:  o_ctrl.kind = K_DIV;
            OP_MAG2: o_ctrl.kind = K_MAG2;
            OP_MAG:  o_ctrl.kind = K_MAG;
            default: o_ctrl.kind = K_NOP;
        endcase
    end

    // magnitude ops square the first operand, so the back end sees a times a
    always_comb begin
        if (o_ctrl.kind == K_MAG2 || o_ctrl.kind == K_MAG) begin
            o_b_re = i_a_re;
            o_b_im = i_a_im;
        end else begin
            o_b_re = i_b_re;
            o_b_im = i_b_im;
        end
    end

endmodule

[rtl/core/cau_queue.sv]
module cau_queue #(
    parameter int DW_Q = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  logic [DW_Q-1:0] i_data,
    output logic            o_full,
    input  logic            i_rd,
    output logic [DW_Q-1:0] o_data,
    output logic            o_empty
);

    localparam int DEPTH = 4;
    localparam int AW    = 2;

    logic [DW_Q-1:0] r_mem [DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [AW:0]     r_cnt;
    logic            wr_ok;
    logic            rd_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ok && !rd_ok) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count lost a write");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_full && o_empty))
        else $error("queue full and empty at once");
`endif

endmodule

[rtl/core/cau_back.sv]
module cau_back
    import cau_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_ctrl               i_ctrl,
    input  logic signed [W-1:0] i_a_re,
    input  logic signed [W-1:0] i_a_im,
    input  logic signed [W-1:0] i_b_re,
    input  logic signed [W-1:0] i_b_im,
    output logic                o_empty,
    input  logic                i_pop,
    output logic signed [W-1:0] o_res_re,
    output logic signed [W-1:0] o_res_im,
    output logic [1:0]          o_status
);

    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 2;
    localparam int DW  = 2 * W + 1;
    localparam int NW  = SW + F;
    localparam int HW  = NW - W;
    localparam int CW  = (HW > DW) ? HW : DW;
    localparam int L   = W + 1;
    localparam int RW  = W + 3;
    localparam int KW  = W + 1;
    localparam int AW1 = W + 1;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    function automatic logic [RW+KW-1:0] sq_step(input logic [RW-1:0] rem,
                                                 input logic [KW-1:0] root,
                                                 input logic [1:0] pair);
        logic [RW-1:0] r2;
        logic [RW-1:0] tr;
        r2 = {1'b0, rem[RW-4:0], pair};
        tr = {root, 2'b01};
        if (r2 >= tr) begin
            return {r2 - tr, root[KW-2:0], 1'b1};
        end
        return {r2, root[KW-2:0], 1'b0};
    endfunction

    function automatic logic [DW:0] dv_step(input logic [DW-1:0] rem,
                                            input logic nb,
                                            input logic [DW-1:0] d);
        logic [DW:0] r2;
        logic [DW:0] dd;
        logic [DW:0] df;
        r2 = {rem, nb};
        dd = {1'b0, d};
        df = r2 - dd;
        if (r2 >= dd) begin
            return {1'b1, df[DW-1:0]};
        end
        return {1'b0, r2[DW-1:0]};
    endfunction

    function automatic logic [W:0] sat_sw(input logic signed [SW-1:0] x);
        if (x > $signed(SW'(MAXV))) begin
            return {1'b1, MAXV};
        end
        if (x < $signed({{(SW-W){1'b1}}, MINV})) begin
            return {1'b1, MINV};
        end
        return {1'b0, x[W-1:0]};
    endfunction

    function automatic logic [W:0] div_res(input logic ovf, input logic [W-1:0] q,
                                           input logic neg);
        if (ovf) begin
            return neg ? {1'b1, MINV} : {1'b1, MAXV};
        end
        if (!neg) begin
            return q[W-1] ? {1'b1, MAXV} : {1'b0, q};
        end
        if (q > MINV) begin
            return {1'b1, MINV};
        end
        return {1'b0, W'(0) - q};
    endfunction

    logic adv;
    logic r_out_v;

    // whole pipeline advances together whenever the output slot frees up
    assign adv     = !r_out_v || i_pop;
    assign o_ready = adv;
    assign o_empty = !r_out_v;

    // stage a: products, and the sum or difference for add and subtract
    logic                  r_a_v;
    t_ctrl                 r_a_ctrl;
    logic signed [PW-1:0]  r_a_p0, r_a_p1, r_a_p2, r_a_p3, r_a_p4, r_a_p5;
    logic signed [AW1-1:0] r_a_as_re, r_a_as_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_ctrl <= i_ctrl;
            r_a_p0   <= PW'(i_a_re) * PW'(i_b_re);
            r_a_p1   <= PW'(i_a_im) * PW'(i_b_im);
            r_a_p2   <= PW'(i_a_re) * PW'(i_b_im);
            r_a_p3   <= PW'(i_a_im) * PW'(i_b_re);
            r_a_p4   <= PW'(i_b_re) * PW'(i_b_re);
            r_a_p5   <= PW'(i_b_im) * PW'(i_b_im);
            if (i_ctrl.kind == K_SUB) begin
                r_a_as_re <= AW1'(i_a_re) - AW1'(i_b_re);
                r_a_as_im <= AW1'(i_a_im) - AW1'(i_b_im);
            end else begin
                r_a_as_re <= AW1'(i_a_re) + AW1'(i_b_re);
                r_a_as_im <= AW1'(i_a_im) + AW1'(i_b_im);
            end
        end
    end

    // stage b: sums
    logic                 r_b_v;
    t_ctrl                r_b_ctrl;
    logic signed [SW-1:0] r_b_re, r_b_im;
    logic [DW-1:0]        r_b_d;
    logic signed [SW-1:0] n_b_re, n_b_im;

    always_comb begin
        unique case (r_a_ctrl.kind) inside
            K_ADD, K_SUB: begin
                n_b_re = SW'(r_a_as_re);
                n_b_im = SW'(r_a_as_im);
            end
            K_MUL: begin
                n_b_re = SW'(r_a_p0) - SW'(r_a_p1);
                n_b_im = SW'(r_a_p2) + SW'(r_a_p3);
            end
            K_DIV: begin
                n_b_re = SW'(r_a_p0) + SW'(r_a_p1);
                n_b_im = SW'(r_a_p3) - SW'(r_a_p2);
            end
            K_MAG2, K_MAG: begin
                n_b_re = SW'(r_a_p0) + SW'(r_a_p1);
                n_b_im = '0;
            end
            default: begin
                n_b_re = '0;
                n_b_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_ctrl <= r_a_ctrl;
            r_b_re   <= n_b_re;
            r_b_im   <= n_b_im;
            r_b_d    <= {1'b0, r_a_p4[PW-1:0]} + {1'b0, r_a_p5[PW-1:0]};
        end
    end

    // stage c: scaling, sign split and numerators
    logic                 r_c_v;
    t_ctrl                r_c_ctrl;
    logic signed [SW-1:0] r_c_val_re, r_c_val_im;
    logic                 r_c_neg_re, r_c_neg_im;
    logic [NW-1:0]        r_c_n_re, r_c_n_im;
    logic [DW-1:0]        r_c_d;
    logic signed [SW-1:0] n_c_val_re, n_c_val_im;
    logic [SW-1:0]        mag_re, mag_im;

    assign mag_re = r_b_re[SW-1] ? SW'(0) - r_b_re : r_b_re;
    assign mag_im = r_b_im[SW-1] ? SW'(0) - r_b_im : r_b_im;

    always_comb begin
        unique case (r_b_ctrl.kind) inside
            K_MUL: begin
                n_c_val_re = r_b_re >>> F;
                n_c_val_im = r_b_im >>> F;
            end
            K_MAG2: begin
                n_c_val_re = r_b_re >>> F;
                n_c_val_im = '0;
            end
            K_ADD, K_SUB: begin
                n_c_val_re = r_b_re;
                n_c_val_im = r_b_im;
            end
            K_MAG: begin
                n_c_val_re = r_b_re;
                n_c_val_im = '0;
            end
            default: begin
                n_c_val_re = '0;
                n_c_val_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_ctrl   <= r_b_ctrl;
            r_c_val_re <= n_c_val_re;
            r_c_val_im <= n_c_val_im;
            r_c_neg_re <= r_b_re[SW-1];
            r_c_neg_im <= r_b_im[SW-1];
            r_c_n_re   <= NW'(mag_re) << F;
            r_c_n_im   <= NW'(mag_im) << F;
            r_c_d      <= r_b_d;
        end
    end

    // bit-per-stage divider and square root, running side by side
    logic                 r_s_v      [L];
    t_ctrl                r_s_ctrl   [L];
    logic signed [SW-1:0] r_s_val_re [L];
    logic signed [SW-1:0] r_s_val_im [L];
    logic                 r_s_neg_re [L];
    logic                 r_s_neg_im [L];
    logic [DW-1:0]        r_s_d      [L];
    logic [DW-1:0]        r_s_drem_re[L];
    logic [DW-1:0]        r_s_drem_im[L];
    logic [W-1:0]         r_s_dq_re  [L];
    logic [W-1:0]         r_s_dq_im  [L];
    logic [W-1:0]         r_s_dlo_re [L];
    logic [W-1:0]         r_s_dlo_im [L];
    logic                 r_s_dovf_re[L];
    logic                 r_s_dovf_im[L];
    logic [RW-1:0]        r_s_srem   [L];
    logic [KW-1:0]        r_s_sroot  [L];
    logic [SW-1:0]        r_s_ss     [L];

    genvar k;
    for (k = 0; k < L; k++) begin : g_stage
        logic                 p_v;
        t_ctrl                p_ctrl;
        logic signed [SW-1:0] p_val_re, p_val_im;
        logic                 p_neg_re, p_neg_im;
        logic [DW-1:0]        p_d;
        logic [SW-1:0]        p_ss;
        logic [RW-1:0]        p_srem;
        logic [KW-1:0]        p_sroot;
        logic [DW-1:0]        n_drem_re, n_drem_im;
        logic [W-1:0]         n_dq_re, n_dq_im;
        logic [W-1:0]         n_dlo_re, n_dlo_im;
        logic                 n_dovf_re, n_dovf_im;
        logic [RW+KW-1:0]     sq;

        if (k == 0) begin : g_first
            logic [CW-1:0] hi_re, hi_im;

            assign p_v      = r_c_v;
            assign p_ctrl   = r_c_ctrl;
            assign p_val_re = r_c_val_re;
            assign p_val_im = r_c_val_im;
            assign p_neg_re = r_c_neg_re;
            assign p_neg_im = r_c_neg_im;
            assign p_d      = r_c_d;
            assign p_ss     = r_c_val_re;
            assign p_srem   = '0;
            assign p_sroot  = '0;

            // quotient fits in W bits unless the top of the numerator reaches d
            assign hi_re     = CW'(r_c_n_re[NW-1:W]);
            assign hi_im     = CW'(r_c_n_im[NW-1:W]);
            assign n_dovf_re = hi_re >= CW'(r_c_d);
            assign n_dovf_im = hi_im >= CW'(r_c_d);
            assign n_drem_re = n_dovf_re ? '0 : hi_re[DW-1:0];
            assign n_drem_im = n_dovf_im ? '0 : hi_im[DW-1:0];
            assign n_dlo_re  = r_c_n_re[W-1:0];
            assign n_dlo_im  = r_c_n_im[W-1:0];
            assign n_dq_re   = '0;
            assign n_dq_im   = '0;
        end else begin : g_next
            logic [DW:0] st_re, st_im;

            assign p_v      = r_s_v[k-1];
            assign p_ctrl   = r_s_ctrl[k-1];
            assign p_val_re = r_s_val_re[k-1];
            assign p_val_im = r_s_val_im[k-1];
            assign p_neg_re = r_s_neg_re[k-1];
            assign p_neg_im = r_s_neg_im[k-1];
            assign p_d      = r_s_d[k-1];
            assign p_ss     = r_s_ss[k-1];
            assign p_srem   = r_s_srem[k-1];
            assign p_sroot  = r_s_sroot[k-1];

            assign st_re     = dv_step(r_s_drem_re[k-1], r_s_dlo_re[k-1][W-1], r_s_d[k-1]);
            assign st_im     = dv_step(r_s_drem_im[k-1], r_s_dlo_im[k-1][W-1], r_s_d[k-1]);
            assign n_drem_re = st_re[DW-1:0];
            assign n_drem_im = st_im[DW-1:0];
            assign n_dq_re   = {r_s_dq_re[k-1][W-2:0], st_re[DW]};
            assign n_dq_im   = {r_s_dq_im[k-1][W-2:0], st_im[DW]};
            assign n_dlo_re  = r_s_dlo_re[k-1] << 1;
            assign n_dlo_im  = r_s_dlo_im[k-1] << 1;
            assign n_dovf_re = r_s_dovf_re[k-1];
            assign n_dovf_im = r_s_dovf_im[k-1];
        end

        assign sq = sq_step(p_srem, p_sroot, p_ss[SW-1:SW-2]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_v[k] <= 1'b0;
            end else if (adv) begin
                r_s_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_s_ctrl[k]    <= p_ctrl;
                r_s_val_re[k]  <= p_val_re;
                r_s_val_im[k]  <= p_val_im;
                r_s_neg_re[k]  <= p_neg_re;
                r_s_neg_im[k]  <= p_neg_im;
                r_s_d[k]       <= p_d;
                r_s_drem_re[k] <= n_drem_re;
                r_s_drem_im[k] <= n_drem_im;
                r_s_dq_re[k]   <= n_dq_re;
                r_s_dq_im[k]   <= n_dq_im;
                r_s_dlo_re[k]  <= n_dlo_re;
                r_s_dlo_im[k]  <= n_dlo_im;
                r_s_dovf_re[k] <= n_dovf_re;
                r_s_dovf_im[k] <= n_dovf_im;
                r_s_srem[k]    <= sq[RW+KW-1:KW];
                r_s_sroot[k]   <= sq[KW-1:0];
                r_s_ss[k]      <= p_ss << 2;
            end
        end
    end

    // result selection and saturation
    logic [W:0]   fin_re_f, fin_im_f;
    logic [W-1:0] fin_re, fin_im;
    logic [1:0]   fin_st;
    logic [KW-1:0] root;

    assign root = r_s_sroot[L-1];

    always_comb begin
        fin_st = ST_OK;
        unique case (r_s_ctrl[L-1].kind) inside
            K_ADD, K_SUB, K_MUL, K_MAG2: begin
                fin_re_f = sat_sw(r_s_val_re[L-1]);
                fin_im_f = sat_sw(r_s_val_im[L-1]);
            end
            K_DIV: begin
                if (r_s_ctrl[L-1].bzero) begin
                    fin_re_f = '0;
                    fin_im_f = '0;
                    fin_st   = ST_DIVZ;
                end else begin
                    fin_re_f = div_res(r_s_dovf_re[L-1], r_s_dq_re[L-1], r_s_neg_re[L-1]);
                    fin_im_f = div_res(r_s_dovf_im[L-1], r_s_dq_im[L-1], r_s_neg_im[L-1]);
                end
            end
            K_MAG: begin
                fin_re_f = (root[KW-1:KW-2] != 2'b00) ? {1'b1, MAXV} : {1'b0, root[W-1:0]};
                fin_im_f = '0;
            end
            default: begin
                fin_re_f = '0;
                fin_im_f = '0;
            end
        endcase
        if (fin_st == ST_OK && (fin_re_f[W] || fin_im_f[W])) begin
            fin_st = ST_SAT;
        end
        fin_re = fin_re_f[W-1:0];
        fin_im = fin_im_f[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_s_v[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_res_re <= fin_re;
            o_res_im <= fin_im;
            o_status <= fin_st;
        end
    end

`ifndef NO_ASSERTIONS
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && o_status == ST_DIVZ) |-> (o_res_re == '0 && o_res_im == '0))
        else $error("division by zero item carries a nonzero result");

    a_mag_im_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_v[L-1] && (r_s_ctrl[L-1].kind == K_MAG || r_s_ctrl[L-1].kind == K_MAG2))
        |-> fin_im == '0)
        else $error("magnitude item with nonzero imaginary part");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && o_status == ST_SAT) |->
        (o_res_re == MAXV || o_res_re == MINV || o_res_im == MAXV || o_res_im == MINV))
        else $error("saturated item has no component at a limit");
`endif

endmodule

[rtl/core/complex_arith_unit.sv]
// Complex arithmetic unit on signed fixed-point components (WORD_BITS wide, FRAC_BITS
// fractional bits). Each item names add, subtract, multiply, divide, magnitude squared or
// magnitude and yields one result with a status (ok, division by zero, saturated). One item
// is taken per clock while results are popped; on its way from push to empty going low an item
// passes the queue, the product, sum and scaling stages, then the divider and square root, which
// resolve one quotient or root bit per pipeline stage, and the output register. A four-entry queue
// between the classifying front and the arithmetic pipeline lets push and pop stall independently.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [2:0]                  i_req_type,
    input  logic signed [WORD_BITS-1:0] i_a_re,
    input  logic signed [WORD_BITS-1:0] i_a_im,
    input  logic signed [WORD_BITS-1:0] i_b_re,
    input  logic signed [WORD_BITS-1:0] i_b_im,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [WORD_BITS-1:0] o_res_re,
    output logic signed [WORD_BITS-1:0] o_res_im,
    output logic [1:0]                  o_status
);

    localparam int W  = WORD_BITS;
    localparam int CB = $bits(t_ctrl);
    localparam int QW = CB + 4 * W;

    t_ctrl               fr_ctrl;
    logic signed [W-1:0] fr_b_re, fr_b_im;
    logic [QW-1:0]       q_wdata, q_rdata;
    logic                q_empty;
    logic                bk_ready;
    t_ctrl               bk_ctrl;

    cau_front #(.W(W)) u_front (
        .i_req_type (i_req_type),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .o_ctrl     (fr_ctrl),
        .o_b_re     (fr_b_re),
        .o_b_im     (fr_b_im)
    );

    assign q_wdata = {fr_ctrl, i_a_re, i_a_im, fr_b_re, fr_b_im};

    cau_queue #(.DW_Q(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_rd    (bk_ready),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign bk_ctrl = t_ctrl'(q_rdata[QW-1:4*W]);

    cau_back #(.W(W), .F(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .o_ready  (bk_ready),
        .i_ctrl   (bk_ctrl),
        .i_a_re   (q_rdata[4*W-1:3*W]),
        .i_a_im   (q_rdata[3*W-1:2*W]),
        .i_b_re   (q_rdata[2*W-1:W]),
        .i_b_im   (q_rdata[W-1:0]),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (o_status)
    );

endmodule
